>>> rtl/mjq_pkg.sv
// shared constants, types and helpers for the minimum-jerk coefficient pipeline
package mjq_pkg;

  localparam int FB        = 16;
  localparam int ST_W      = 32;
  localparam int DUR_W     = 24;
  localparam int DURS_W    = DUR_W + 1;
  localparam int COEF_W    = 64;
  localparam int Q_W       = 64;
  localparam int NUM_W     = (FB > 16) ? 2 * FB + 64 : 96;
  localparam int DEN_W     = 5 * DUR_W;
  localparam int D2_W      = DEN_W + 1;
  localparam int X_W       = NUM_W + 2 * FB + 33;
  localparam int SH3       = 31;
  localparam int SH4       = FB + 31;
  localparam int SH5       = 2 * FB + 31;
  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT   = Q_W + 2;
  localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT;

  typedef struct packed {
    logic signed [ST_W-1:0] start_position;
    logic signed [ST_W-1:0] start_velocity;
    logic signed [ST_W-1:0] start_accel;
    logic signed [ST_W-1:0] end_position;
    logic signed [ST_W-1:0] end_velocity;
    logic signed [ST_W-1:0] end_accel;
    logic [DUR_W-1:0]       duration;
  } traj_t;

  // dividend and divisor for one rounded division
  typedef struct packed {
    logic             neg;
    logic [X_W-1:0]   x;
    logic [DEN_W-1:0] den;
  } div_in_t;

  // x = 2*|num|*2^sh + den, so floor(x / 2den) rounds ties away from zero
  function automatic div_in_t make_div(input logic signed [NUM_W-1:0] num,
                                       input logic [DEN_W-1:0] den, input int sh);
    div_in_t          d;
    logic [NUM_W-1:0] mag;
    mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    d.neg = num[NUM_W-1];
    d.x   = (X_W'(mag) << (sh + 1)) + X_W'(den);
    d.den = den;
    return d;
  endfunction

endpackage

>>> rtl/mjq_in_if.sv
// request channel: start state, end state and duration
interface mjq_in_if import mjq_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic signed [ST_W-1:0] start_position;
  logic signed [ST_W-1:0] start_velocity;
  logic signed [ST_W-1:0] start_accel;
  logic signed [ST_W-1:0] end_position;
  logic signed [ST_W-1:0] end_velocity;
  logic signed [ST_W-1:0] end_accel;
  logic [DUR_W-1:0]       duration;

  modport source (output valid, start_position, start_velocity, start_accel,
                  end_position, end_velocity, end_accel, duration, input ready);
  modport sink (input valid, start_position, start_velocity, start_accel,
                end_position, end_velocity, end_accel, duration, output ready);
endinterface

>>> rtl/mjq_out_if.sv
// result channel: six polynomial coefficients and the bad duration flag
interface mjq_out_if import mjq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef0;
  logic signed [COEF_W-1:0] coef1;
  logic signed [COEF_W-1:0] coef2;
  logic signed [COEF_W-1:0] coef3;
  logic signed [COEF_W-1:0] coef4;
  logic signed [COEF_W-1:0] coef5;
  logic                     bad_duration;

  modport source (output valid, coef0, coef1, coef2, coef3, coef4, coef5, bad_duration,
                  input ready);
  modport sink (input valid, coef0, coef1, coef2, coef3, coef4, coef5, bad_duration,
                output ready);
endinterface

>>> rtl/min_jerk_quintic_coefficients.sv
// Minimum-jerk quintic coefficients: takes one request per clock unless stalled and returns
// c0..c5 after 5 front stages for residuals and powers of T and a 66-stage divider (one range
// check, 64 quotient stages of one compare and subtract each, one saturation register);
// throughput is one item per cycle when not stalled. The whole pipeline advances together
// whenever the last stage is empty or the consumer takes its item, so a stall freezes every
// stage without loss. States are Q16.16, duration Q8.16 and coefficients Q32.32; c3..c5 are
// rounded to nearest with ties away from zero and saturated; a zero duration raises
// bad_duration and forces all coefficients to 0.
module min_jerk_quintic_coefficients import mjq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mjq_in_if.sink     traj,
  mjq_out_if.source  coef
);

  logic                   en;
  logic [PIPE_LAT-1:0]    vld;
  traj_t                  req;
  div_in_t                div3, div4, div5;
  logic signed [COEF_W-1:0] c3, c4, c5;

  // sideband for the exact coefficients and the error flag
  logic signed [ST_W-1:0] sb_p0  [0:PIPE_LAT-1];
  logic signed [ST_W-1:0] sb_v0  [0:PIPE_LAT-1];
  logic signed [ST_W-1:0] sb_a0  [0:PIPE_LAT-1];
  logic                   sb_bad [0:PIPE_LAT-1];

  // global advance: last stage empty or being taken
  assign en         = ~vld[PIPE_LAT-1] | coef.ready;
  assign traj.ready = en;

  assign req.start_position = traj.start_position;
  assign req.start_velocity = traj.start_velocity;
  assign req.start_accel    = traj.start_accel;
  assign req.end_position   = traj.end_position;
  assign req.end_velocity   = traj.end_velocity;
  assign req.end_accel      = traj.end_accel;
  assign req.duration       = traj.duration;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], traj.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_p0[0]  <= traj.start_position;
      sb_v0[0]  <= traj.start_velocity;
      sb_a0[0]  <= traj.start_accel;
      sb_bad[0] <= (traj.duration == '0);
      for (int i = 1; i < PIPE_LAT; i++) begin
        sb_p0[i]  <= sb_p0[i-1];
        sb_v0[i]  <= sb_v0[i-1];
        sb_a0[i]  <= sb_a0[i-1];
        sb_bad[i] <= sb_bad[i-1];
      end
    end
  end

  mjq_front u_front (
    .clk  (clk),
    .en   (en),
    .req  (req),
    .div3 (div3),
    .div4 (div4),
    .div5 (div5)
  );

  mjq_div u_div3 (.clk(clk), .en(en), .din(div3), .coef(c3));
  mjq_div u_div4 (.clk(clk), .en(en), .din(div4), .coef(c4));
  mjq_div u_div5 (.clk(clk), .en(en), .din(div5), .coef(c5));

  // c0, c1, c2 are exact shifts of the start state
  assign coef.valid        = vld[PIPE_LAT-1];
  assign coef.bad_duration = sb_bad[PIPE_LAT-1];
  assign coef.coef0 = sb_bad[PIPE_LAT-1] ? '0 : (COEF_W'(sb_p0[PIPE_LAT-1]) <<< (32 - FB));
  assign coef.coef1 = sb_bad[PIPE_LAT-1] ? '0 : (COEF_W'(sb_v0[PIPE_LAT-1]) <<< (32 - FB));
  assign coef.coef2 = sb_bad[PIPE_LAT-1] ? '0 : (COEF_W'(sb_a0[PIPE_LAT-1]) <<< (31 - FB));
  assign coef.coef3 = sb_bad[PIPE_LAT-1] ? '0 : c3;
  assign coef.coef4 = sb_bad[PIPE_LAT-1] ? '0 : c4;
  assign coef.coef5 = sb_bad[PIPE_LAT-1] ? '0 : c5;

  // a zero duration gives zero c0 and c3..c5
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (coef.valid && coef.bad_duration) |-> (coef.coef3 == '0 && coef.coef4 == '0 &&
                                           coef.coef5 == '0 && coef.coef0 == '0))
    else $error("bad duration with nonzero coefficients");

  // an accepted zero duration enters the first stage flagged
  a_bad_entry: assert property (@(posedge clk) disable iff (rst)
    (traj.valid && traj.ready && traj.duration == '0) |=> (vld[0] && sb_bad[0]))
    else $error("zero duration not flagged on entry");

  // a stalled pipeline keeps every valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");

endmodule

>>> rtl/mjq_front.sv
// residual numerators and powers of the duration, five register stages
module mjq_front import mjq_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  traj_t   req,
  output div_in_t div3,
  output div_in_t div4,
  output div_in_t div5
);

  logic signed [DURS_W-1:0]       durs0;
  // stage 1
  logic signed [ST_W:0]           dp1, da1;
  logic signed [ST_W-1:0]         a0_1;
  logic signed [ST_W+DURS_W-1:0]  v0d1;
  logic signed [ST_W+DUR_W:0]     dvd1;
  logic [DUR_W-1:0]               dur1;
  logic [2*DUR_W-1:0]             d2_1;
  // stage 2, products split on the 24-bit halves of T^2
  logic signed [DURS_W-1:0]       d2los, d2his;
  logic signed [ST_W+DUR_W-1:0]   a0lo2, a0hi2;
  logic signed [ST_W+DUR_W:0]     dalo2, dahi2;
  logic signed [ST_W+DUR_W:0]     dvd2;
  logic signed [NUM_W-1:0]        hp2;
  logic [DUR_W-1:0]               dur2;
  logic [2*DUR_W-1:0]             d3lo2, d3hi2, d4ll2, d4lh2, d4hh2;
  // stage 3
  logic signed [NUM_W-1:0]        a0dd;
  logic signed [NUM_W-1:0]        hn3, dvd3, dad3;
  logic [DUR_W-1:0]               dur3;
  logic [3*DUR_W-1:0]             d3_3;
  logic [4*DUR_W-1:0]             d4_3;
  // stage 4
  logic signed [NUM_W-1:0]        n3_4, n4_4, n5_4;
  logic [3*DUR_W-1:0]             d3_4;
  logic [4*DUR_W-1:0]             d4_4;
  logic [2*DUR_W-1:0]             d5p4 [0:3];
  logic [DEN_W-1:0]               d5;

  assign durs0 = $signed({1'b0, req.duration});
  assign d2los = $signed({1'b0, d2_1[DUR_W-1:0]});
  assign d2his = $signed({1'b0, d2_1[2*DUR_W-1:DUR_W]});
  // a0 * T^2 from its two partial products
  assign a0dd  = (NUM_W'(a0hi2) <<< DUR_W) + NUM_W'(a0lo2);
  // T^5 from four 24-bit slices of T^4
  assign d5    = (DEN_W'(d5p4[3]) << (3 * DUR_W)) + (DEN_W'(d5p4[2]) << (2 * DUR_W)) +
                 (DEN_W'(d5p4[1]) << DUR_W) + DEN_W'(d5p4[0]);

  always_ff @(posedge clk) begin
    if (en) begin
      dp1   <= (ST_W+1)'(req.end_position) - (ST_W+1)'(req.start_position);
      da1   <= (ST_W+1)'(req.end_accel) - (ST_W+1)'(req.start_accel);
      dvd1  <= ((ST_W+DUR_W+1)'(req.end_velocity) - (ST_W+DUR_W+1)'(req.start_velocity)) *
               durs0;
      a0_1  <= req.start_accel;
      v0d1  <= req.start_velocity * durs0;
      dur1  <= req.duration;
      d2_1  <= req.duration * req.duration;

      a0lo2 <= a0_1 * d2los;
      a0hi2 <= a0_1 * d2his;
      dalo2 <= da1 * d2los;
      dahi2 <= da1 * d2his;
      dvd2  <= dvd1;
      hp2   <= (NUM_W'(dp1) <<< (2 * FB + 1)) - (NUM_W'(v0d1) <<< (FB + 1));
      dur2  <= dur1;
      d3lo2 <= d2_1[DUR_W-1:0] * dur1;
      d3hi2 <= d2_1[2*DUR_W-1:DUR_W] * dur1;
      d4ll2 <= d2_1[DUR_W-1:0] * d2_1[DUR_W-1:0];
      d4lh2 <= d2_1[DUR_W-1:0] * d2_1[2*DUR_W-1:DUR_W];
      d4hh2 <= d2_1[2*DUR_W-1:DUR_W] * d2_1[2*DUR_W-1:DUR_W];

      // dv * T is folded in here: (dv*T << F) - a0*T^2
      hn3   <= hp2 - a0dd;
      dvd3  <= (NUM_W'(dvd2) <<< FB) - a0dd;
      dad3  <= (NUM_W'(dahi2) <<< DUR_W) + NUM_W'(dalo2);
      dur3  <= dur2;
      d3_3  <= ((3*DUR_W)'(d3hi2) << DUR_W) + (3*DUR_W)'(d3lo2);
      d4_3  <= ((4*DUR_W)'(d4hh2) << (2 * DUR_W)) + ((4*DUR_W)'(d4lh2) << (DUR_W + 1)) +
               (4*DUR_W)'(d4ll2);

      n3_4  <= hn3 * 10 - dvd3 * 8 + dad3;
      n4_4  <= dvd3 * 14 - hn3 * 15 - dad3 * 2;
      n5_4  <= hn3 * 6 - dvd3 * 6 + dad3;
      d3_4  <= d3_3;
      d4_4  <= d4_3;
      for (int i = 0; i < 4; i++) begin
        d5p4[i] <= d4_3[i*DUR_W +: DUR_W] * dur3;
      end

      div3  <= make_div(n3_4, DEN_W'(d3_4), SH3);
      div4  <= make_div(n4_4, DEN_W'(d4_4), SH4);
      div5  <= make_div(n5_4, d5, SH5);
    end
  end

endmodule

>>> rtl/mjq_div.sv
// pipelined restoring divider, one quotient bit per stage, saturated signed result
module mjq_div import mjq_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  div_in_t                  din,
  output logic signed [COEF_W-1:0] coef
);

  logic [D2_W-1:0] rem  [0:Q_W];
  logic [D2_W-1:0] dvs  [0:Q_W];
  logic [Q_W-1:0]  xlo  [0:Q_W];
  logic [Q_W-1:0]  quo  [0:Q_W];
  logic            neg  [0:Q_W];
  logic            big  [0:Q_W];
  logic [D2_W-1:0] d2_in;
  logic [Q_W-1:0]  lo;

  assign d2_in = {din.den, 1'b0};

  // quotient must fit in the low bits, otherwise the result saturates
  always_ff @(posedge clk) begin
    if (en) begin
      big[0] <= (X_W'(din.x[X_W-1:Q_W]) >= X_W'(d2_in));
      rem[0] <= D2_W'(din.x[X_W-1:Q_W]);
      dvs[0] <= d2_in;
      xlo[0] <= din.x[Q_W-1:0];
      quo[0] <= '0;
      neg[0] <= din.neg;
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic [D2_W:0] trial;
    logic          ge;
    assign trial = {rem[i], xlo[i][Q_W-1]};
    assign ge    = (trial >= {1'b0, dvs[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? D2_W'(trial - {1'b0, dvs[i]}) : D2_W'(trial);
        dvs[i+1] <= dvs[i];
        xlo[i+1] <= {xlo[i][Q_W-2:0], 1'b0};
        quo[i+1] <= {quo[i][Q_W-2:0], ge};
        neg[i+1] <= neg[i];
        big[i+1] <= big[i];
      end
    end
  end

  assign lo = quo[Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[Q_W]) begin
        if (big[Q_W] || (lo > {1'b1, {(Q_W-1){1'b0}}})) begin
          coef <= {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
          coef <= -$signed(lo);
        end
      end else begin
        if (big[Q_W] || lo[Q_W-1]) begin
          coef <= {1'b0, {(COEF_W-1){1'b1}}};
        end else begin
          coef <= $signed(lo);
        end
      end
    end
  end

endmodule
